[rtl/bca_pkg.sv]
package bca_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int MAX_CHUNKS = 16;
  localparam int SIZE_W     = 16;
  localparam int BLK_W      = 4;
  localparam int CHK_W      = 4;
  localparam int SLOT_W     = BLK_W + CHK_W;
  localparam int STAT_W     = 3;

  localparam logic [SIZE_W-1:0] DEFAULT_SIZE = SIZE_W'(1000);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_ROOM  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FREED    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FREED_RS = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD      = 3'd5;

  localparam logic [1:0] K_ALLOC = 2'd0;
  localparam logic [1:0] K_ZERO  = 2'd1;
  localparam logic [1:0] K_FREE  = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SIZE_W-1:0] size;
    logic [BLK_W-1:0]  blk;
    logic [CHK_W-1:0]  chk;
  } item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  blk;
    logic [CHK_W-1:0]  chk;
    logic [SIZE_W-1:0] offset;
    logic [SIZE_W-1:0] size;
  } res_t;

  typedef struct packed {
    logic [SIZE_W-1:0] start;
    logic [SIZE_W-1:0] len;
    logic              is_free;
  } chunk_t;

endpackage

[rtl/bca_front.sv]
module bca_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_cmd,
  input  logic [15:0]    in_alloc_size,
  input  logic [3:0]     in_block_index,
  input  logic [3:0]     in_chunk_index,
  output logic           q_valid,
  output bca_pkg::item_t q_item,
  input  logic           q_pop
);

  bca_pkg::item_t fifo_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  bca_pkg::item_t cls;
  logic           push, pop;

  // Classify the item before it is queued so the back end branches at once.
  always_comb begin
    cls.size = in_alloc_size;
    cls.blk  = in_block_index;
    cls.chk  = in_chunk_index;
    if (in_cmd == bca_pkg::CMD_FREE) begin
      cls.kind = bca_pkg::K_FREE;
    end else if (in_alloc_size == '0) begin
      cls.kind = bca_pkg::K_ZERO;
    end else begin
      cls.kind = bca_pkg::K_ALLOC;
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[rtl/bca_back.sv]
module bca_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [bca_pkg::SIZE_W-1:0] dflt_size,
  input  logic                       q_valid,
  input  bca_pkg::item_t             q_item,
  output logic                       q_pop,
  input  logic                       out_free,
  output logic                       res_valid,
  output bca_pkg::res_t              res
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FCHK = 3'd1;
  localparam logic [2:0] S_BLK  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_NEW  = 3'd4;

  localparam int BO_W  = bca_pkg::BLK_W + 1;
  localparam int CNT_W = bca_pkg::CHK_W + 1;

  logic [2:0]                 state_r, state_nxt;
  bca_pkg::item_t             cur_r, cur_nxt;
  logic [bca_pkg::BLK_W-1:0]  bi_r, bi_nxt;
  logic [bca_pkg::CHK_W-1:0]  c_r, c_nxt;
  logic [BO_W-1:0]            bo_r, bo_nxt;

  logic [bca_pkg::SIZE_W-1:0] cap_r  [bca_pkg::MAX_BLOCKS];
  logic [bca_pkg::SIZE_W-1:0] bump_r [bca_pkg::MAX_BLOCKS];
  logic [bca_pkg::SIZE_W-1:0] used_r [bca_pkg::MAX_BLOCKS];
  logic [CNT_W-1:0]           cnt_r  [bca_pkg::MAX_BLOCKS];

  bca_pkg::chunk_t            cmem [bca_pkg::MAX_BLOCKS * bca_pkg::MAX_CHUNKS];
  bca_pkg::chunk_t            rdata_r;

  logic [bca_pkg::BLK_W-1:0]  tidx;
  logic [bca_pkg::SIZE_W-1:0] t_cap, t_bump, t_used, room;
  logic [CNT_W-1:0]           t_cnt;

  logic                       tb_we, tb_cap_we;
  logic [bca_pkg::BLK_W-1:0]  tb_widx;
  logic [bca_pkg::SIZE_W-1:0] tb_cap_w, tb_bump_w, tb_used_w;
  logic [CNT_W-1:0]           tb_cnt_w;

  logic                       cm_we;
  logic [bca_pkg::SLOT_W-1:0] cm_waddr, cm_raddr;
  bca_pkg::chunk_t            cm_wdata;
  logic                       hit;

  always_comb begin
    tidx   = (state_r == S_IDLE) ? q_item.blk : bi_r;
    t_cap  = cap_r[tidx];
    t_bump = bump_r[tidx];
    t_used = used_r[tidx];
    t_cnt  = cnt_r[tidx];
    room   = t_cap - t_bump;
    hit    = rdata_r.is_free && (cur_r.size <= rdata_r.len);
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    bi_nxt    = bi_r;
    c_nxt     = c_r;
    bo_nxt    = bo_r;
    q_pop     = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    tb_we     = 1'b0;
    tb_cap_we = 1'b0;
    tb_widx   = bi_r;
    tb_cap_w  = t_cap;
    tb_bump_w = t_bump;
    tb_used_w = t_used;
    tb_cnt_w  = t_cnt;
    cm_we     = 1'b0;
    cm_waddr  = {bi_r, c_r};
    cm_wdata  = rdata_r;
    cm_raddr  = {bi_r, c_r};

    case (state_r)
      S_IDLE: begin
        cm_raddr = {q_item.blk, q_item.chk};
        if (q_valid && out_free) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          case (q_item.kind)
            bca_pkg::K_ZERO: begin
              res_valid  = 1'b1;
              res.status = bca_pkg::ST_ZERO;
            end
            bca_pkg::K_FREE: begin
              if ({1'b0, q_item.blk} >= bo_r || {1'b0, q_item.chk} >= t_cnt) begin
                res_valid  = 1'b1;
                res.status = bca_pkg::ST_BAD;
              end else begin
                bi_nxt    = q_item.blk;
                c_nxt     = q_item.chk;
                state_nxt = S_FCHK;
              end
            end
            default: begin
              if (bo_r == '0) begin
                state_nxt = S_NEW;
              end else begin
                bi_nxt    = bca_pkg::BLK_W'(bo_r - 1'b1);
                state_nxt = S_BLK;
              end
            end
          endcase
        end
      end

      S_FCHK: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
          if (rdata_r.is_free) begin
            res.status = bca_pkg::ST_BAD;
          end else if (t_used == rdata_r.len) begin
            // Last used chunk: the whole block starts over empty.
            res.status = bca_pkg::ST_FREED_RS;
            tb_we      = 1'b1;
            tb_bump_w  = '0;
            tb_used_w  = '0;
            tb_cnt_w   = '0;
          end else begin
            res.status       = bca_pkg::ST_FREED;
            tb_we            = 1'b1;
            tb_used_w        = t_used - rdata_r.len;
            cm_we            = 1'b1;
            cm_wdata.is_free = 1'b1;
          end
        end
      end

      S_BLK: begin
        cm_raddr = {bi_r, bca_pkg::CHK_W'(t_cnt - 1'b1)};
        if (cur_r.size <= room && t_cnt < CNT_W'(bca_pkg::MAX_CHUNKS)) begin
          if (out_free) begin
            res_valid      = 1'b1;
            res.status     = bca_pkg::ST_GRANTED;
            res.blk        = bi_r;
            res.chk        = bca_pkg::CHK_W'(t_cnt);
            res.offset     = t_bump;
            res.size       = cur_r.size;
            tb_we          = 1'b1;
            tb_bump_w      = t_bump + cur_r.size;
            tb_used_w      = t_used + cur_r.size;
            tb_cnt_w       = t_cnt + 1'b1;
            cm_we          = 1'b1;
            cm_waddr       = {bi_r, bca_pkg::CHK_W'(t_cnt)};
            cm_wdata.start = t_bump;
            cm_wdata.len   = cur_r.size;
            cm_wdata.is_free = 1'b0;
            state_nxt      = S_IDLE;
          end
        end else if (t_cnt != '0) begin
          c_nxt     = bca_pkg::CHK_W'(t_cnt - 1'b1);
          state_nxt = S_SCAN;
        end else if (bi_r == '0) begin
          state_nxt = S_NEW;
        end else begin
          bi_nxt = bi_r - 1'b1;
        end
      end

      S_SCAN: begin
        // rdata_r holds slot c_r; on a miss the next lower slot is fetched meanwhile.
        if (hit) begin
          cm_raddr = {bi_r, c_r};
          if (out_free) begin
            res_valid        = 1'b1;
            res.status       = bca_pkg::ST_GRANTED;
            res.blk          = bi_r;
            res.chk          = c_r;
            res.offset       = rdata_r.start;
            res.size         = rdata_r.len;
            tb_we            = 1'b1;
            tb_used_w        = t_used + rdata_r.len;
            cm_we            = 1'b1;
            cm_wdata.is_free = 1'b0;
            state_nxt        = S_IDLE;
          end
        end else begin
          cm_raddr = {bi_r, c_r - 1'b1};
          if (c_r != '0) begin
            c_nxt = c_r - 1'b1;
          end else if (bi_r == '0) begin
            state_nxt = S_NEW;
          end else begin
            bi_nxt    = bi_r - 1'b1;
            state_nxt = S_BLK;
          end
        end
      end

      S_NEW: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
          if (bo_r >= BO_W'(bca_pkg::MAX_BLOCKS)) begin
            res.status = bca_pkg::ST_NO_ROOM;
          end else begin
            res.status       = bca_pkg::ST_GRANTED;
            res.blk          = bca_pkg::BLK_W'(bo_r);
            res.size         = cur_r.size;
            tb_we            = 1'b1;
            tb_cap_we        = 1'b1;
            tb_widx          = bca_pkg::BLK_W'(bo_r);
            tb_cap_w         = (dflt_size < cur_r.size) ? cur_r.size : dflt_size;
            tb_bump_w        = cur_r.size;
            tb_used_w        = cur_r.size;
            tb_cnt_w         = CNT_W'(1);
            cm_we            = 1'b1;
            cm_waddr         = {bca_pkg::BLK_W'(bo_r), bca_pkg::CHK_W'(0)};
            cm_wdata.start   = '0;
            cm_wdata.len     = cur_r.size;
            cm_wdata.is_free = 1'b0;
            bo_nxt           = bo_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bo_r    <= '0;
    end else begin
      state_r <= state_nxt;
      bo_r    <= bo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    bi_r  <= bi_nxt;
    c_r   <= c_nxt;
    if (tb_we) begin
      bump_r[tb_widx] <= tb_bump_w;
      used_r[tb_widx] <= tb_used_w;
      cnt_r[tb_widx]  <= tb_cnt_w;
    end
    if (tb_cap_we) begin
      cap_r[tb_widx] <= tb_cap_w;
    end
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[cm_waddr] <= cm_wdata;
    end
    rdata_r <= cmem[cm_raddr];
  end

endmodule

[rtl/block_chunk_allocator.sv]
// A zero-size request or a bad handle caught at once is answered from the back end's idle
// state; a free first reads its chunk entry; an allocate tries the open blocks from the
// newest down, bump room then freed chunk slots, and opens a new block if none fits.
// Throughput: one item at a time in the back end, set by the chunk-table read port,
// one chunk entry per cycle; a 2-item queue keeps accepting meanwhile until full.
// Reset: synchronous active-low; no blocks open, default block size back to 1000.
module block_chunk_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_default_block_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_alloc_size,
  input  logic [3:0]  in_block_index,
  input  logic [3:0]  in_chunk_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [3:0]  out_granted_block,
  output logic [3:0]  out_granted_chunk,
  output logic [15:0] out_granted_offset,
  output logic [15:0] out_granted_size
);

  logic [15:0]    dflt_r;
  logic           out_valid_r;
  bca_pkg::res_t  out_r;
  logic           q_valid, q_pop, out_free, res_valid;
  bca_pkg::item_t q_item;
  bca_pkg::res_t  res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  bca_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_alloc_size  (in_alloc_size),
    .in_block_index (in_block_index),
    .in_chunk_index (in_chunk_index),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  bca_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dflt_size (dflt_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_r      <= bca_pkg::DEFAULT_SIZE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        dflt_r <= cfg_default_block_size;
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_r.status;
  assign out_granted_block  = out_r.blk;
  assign out_granted_chunk  = out_r.chk;
  assign out_granted_offset = out_r.offset;
  assign out_granted_size   = out_r.size;

endmodule

[tb/block_chunk_allocator_check.sv]
`timescale 1ns / 1ps

module block_chunk_allocator_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_default_block_size,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_alloc_size,
  input  logic [3:0]  in_block_index,
  input  logic [3:0]  in_chunk_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic [3:0]  out_granted_block,
  input  logic [3:0]  out_granted_chunk,
  input  logic [15:0] out_granted_offset,
  input  logic [15:0] out_granted_size,
  output int          errors,
  output int          pending
);

  localparam int unsigned SIZE_MASK = (1 << bca_pkg::SIZE_W) - 1;

  // Mirror of the allocator tables.
  int unsigned new_block_size;
  int unsigned open_blocks;
  int unsigned blk_cap   [bca_pkg::MAX_BLOCKS];
  int unsigned blk_bump  [bca_pkg::MAX_BLOCKS];
  int unsigned blk_used  [bca_pkg::MAX_BLOCKS];
  int unsigned blk_chunks[bca_pkg::MAX_BLOCKS];
  int unsigned chk_start [bca_pkg::MAX_BLOCKS*bca_pkg::MAX_CHUNKS];
  int unsigned chk_len   [bca_pkg::MAX_BLOCKS*bca_pkg::MAX_CHUNKS];
  bit          chk_free  [bca_pkg::MAX_BLOCKS*bca_pkg::MAX_CHUNKS];

  bca_pkg::res_t grant_q[$];

  function automatic bca_pkg::res_t grant(int unsigned s);
    bca_pkg::res_t r;
    int unsigned bi, c, slot;
    int b, k;
    r = '0;
    if (s == 0) begin
      r.status = bca_pkg::ST_ZERO;
      return r;
    end
    for (b = open_blocks; b > 0; b--) begin
      bi = b - 1;
      if (s <= blk_cap[bi] - blk_bump[bi] && blk_chunks[bi] < bca_pkg::MAX_CHUNKS) begin
        c = blk_chunks[bi];
        slot = bi * bca_pkg::MAX_CHUNKS + c;
        chk_start[slot] = blk_bump[bi];
        chk_len[slot] = s;
        chk_free[slot] = 0;
        blk_bump[bi] = (blk_bump[bi] + s) & SIZE_MASK;
        blk_used[bi] = (blk_used[bi] + s) & SIZE_MASK;
        blk_chunks[bi] = c + 1;
        r.status = bca_pkg::ST_GRANTED;
        r.blk = bca_pkg::BLK_W'(bi);
        r.chk = bca_pkg::CHK_W'(c);
        r.offset = bca_pkg::SIZE_W'(chk_start[slot]);
        r.size = bca_pkg::SIZE_W'(s);
        return r;
      end
      // No bump room or no spare slot: reuse the newest free chunk that is large enough.
      for (k = blk_chunks[bi]; k > 0; k--) begin
        slot = bi * bca_pkg::MAX_CHUNKS + k - 1;
        if (chk_free[slot] && s <= chk_len[slot]) begin
          chk_free[slot] = 0;
          blk_used[bi] = (blk_used[bi] + chk_len[slot]) & SIZE_MASK;
          r.status = bca_pkg::ST_GRANTED;
          r.blk = bca_pkg::BLK_W'(bi);
          r.chk = bca_pkg::CHK_W'(k - 1);
          r.offset = bca_pkg::SIZE_W'(chk_start[slot]);
          r.size = bca_pkg::SIZE_W'(chk_len[slot]);
          return r;
        end
      end
    end
    if (open_blocks >= bca_pkg::MAX_BLOCKS) begin
      r.status = bca_pkg::ST_NO_ROOM;
      return r;
    end
    bi = open_blocks;
    blk_cap[bi] = (new_block_size < s) ? s : new_block_size;
    blk_bump[bi] = s;
    blk_used[bi] = s;
    blk_chunks[bi] = 1;
    slot = bi * bca_pkg::MAX_CHUNKS;
    chk_start[slot] = 0;
    chk_len[slot] = s;
    chk_free[slot] = 0;
    open_blocks = bi + 1;
    r.status = bca_pkg::ST_GRANTED;
    r.blk = bca_pkg::BLK_W'(bi);
    r.size = bca_pkg::SIZE_W'(s);
    return r;
  endfunction

  function automatic bca_pkg::res_t release_chunk(int unsigned b, int unsigned c);
    bca_pkg::res_t r;
    int unsigned slot;
    r = '0;
    r.status = bca_pkg::ST_BAD;
    if (b >= open_blocks || c >= blk_chunks[b]) return r;
    slot = b * bca_pkg::MAX_CHUNKS + c;
    if (chk_free[slot]) return r;
    if (blk_used[b] == chk_len[slot]) begin
      // Last live chunk: the whole block starts over empty.
      blk_bump[b] = 0;
      blk_used[b] = 0;
      blk_chunks[b] = 0;
      r.status = bca_pkg::ST_FREED_RS;
      return r;
    end
    chk_free[slot] = 1;
    blk_used[b] = (blk_used[b] - chk_len[slot]) & SIZE_MASK;
    r.status = bca_pkg::ST_FREED;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    bca_pkg::res_t want;
    if (!rst_n) begin
      new_block_size = 32'(bca_pkg::DEFAULT_SIZE);
      open_blocks = 0;
      grant_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) new_block_size = 32'(cfg_default_block_size);
      if (out_valid && out_ready) begin
        if (grant_q.size() == 0) begin
          $error("result item arrived with none expected");
          errors++;
        end else begin
          want = grant_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("granted_block", 32'(want.blk), 32'(out_granted_block));
          check_field("granted_chunk", 32'(want.chk), 32'(out_granted_chunk));
          check_field("granted_offset", 32'(want.offset), 32'(out_granted_offset));
          check_field("granted_size", 32'(want.size), 32'(out_granted_size));
        end
      end
      if (in_valid && in_ready) begin
        if (in_cmd == bca_pkg::CMD_ALLOC) grant_q.push_back(grant(32'(in_alloc_size)));
        else grant_q.push_back(release_chunk(32'(in_block_index), 32'(in_chunk_index)));
      end
    end
    pending <= grant_q.size();
  end

endmodule

[tb/block_chunk_allocator_test.sv]
`timescale 1ns / 1ps

module block_chunk_allocator_test;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_default_block_size;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [15:0] in_alloc_size;
  logic [3:0]  in_block_index;
  logic [3:0]  in_chunk_index;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [3:0]  out_granted_block;
  logic [3:0]  out_granted_chunk;
  logic [15:0] out_granted_offset;
  logic [15:0] out_granted_size;

  int errors;
  int pending;
  bit quiet;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int idle_cycles;
  int items_sent;
  int grants_seen;
  logic [7:0] live_handles[$];

  block_chunk_allocator dut (.*);

  block_chunk_allocator_check checker_i (.*);

  always #1 clk = ~clk;

  // Result side: random short stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Collect granted handles so that most frees name a live chunk.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_status == bca_pkg::ST_GRANTED) begin
      live_handles.push_back({out_granted_block, out_granted_chunk});
      grants_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send(logic cmd, logic [15:0] size, logic [3:0] blk, logic [3:0] chk);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_alloc_size <= size;
    in_block_index <= blk;
    in_chunk_index <= chk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic set_block_size(logic [15:0] size);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_default_block_size <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    int idx;
    logic [7:0] h;
    pick = $urandom_range(0, 99);
    if (pick < 40 && live_handles.size() > 0) begin
      idx = $urandom_range(0, live_handles.size() - 1);
      h = live_handles[idx];
      live_handles.delete(idx);
      send(bca_pkg::CMD_FREE, 16'($urandom), h[7:4], h[3:0]);
    end else if (pick < 46) begin
      send(bca_pkg::CMD_FREE, 16'($urandom), 4'($urandom), 4'($urandom));
    end else if (pick < 48) begin
      send(bca_pkg::CMD_ALLOC, 16'd0, 4'($urandom), 4'($urandom));
    end else if (pick < 80) begin
      send(bca_pkg::CMD_ALLOC, 16'($urandom_range(1, 64)), 4'($urandom), 4'($urandom));
    end else if (pick < 95) begin
      send(bca_pkg::CMD_ALLOC, 16'($urandom_range(1, 2000)), 4'($urandom), 4'($urandom));
    end else begin
      send(bca_pkg::CMD_ALLOC, 16'($urandom), 4'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    logic [15:0] phase_sizes[5];
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_default_block_size = '0;
    in_valid = 1'b0;
    in_cmd = bca_pkg::CMD_ALLOC;
    in_alloc_size = '0;
    in_block_index = '0;
    in_chunk_index = '0;
    phase_sizes = '{16'd1000, 16'd65535, 16'd1, 16'($urandom_range(2, 4000)), 16'd200};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening under the reset block size.
    send(bca_pkg::CMD_ALLOC, 16'd0, 4'd0, 4'd0);          // zero size refused
    send(bca_pkg::CMD_FREE, 16'd0, 4'd0, 4'd0);           // nothing open yet
    send(bca_pkg::CMD_ALLOC, 16'd65535, 4'd15, 4'd15);    // oversized first block
    send(bca_pkg::CMD_ALLOC, 16'd1, 4'd0, 4'd0);          // forces a new default block
    send(bca_pkg::CMD_FREE, 16'd0, 4'd0, 4'd0);           // last chunk: block resets
    send(bca_pkg::CMD_FREE, 16'd0, 4'd0, 4'd0);           // chunk list now empty
    send(bca_pkg::CMD_FREE, 16'd0, 4'd15, 4'd15);         // block never opened
    send(bca_pkg::CMD_ALLOC, 16'd300, 4'd0, 4'd0);
    send(bca_pkg::CMD_ALLOC, 16'd300, 4'd0, 4'd0);
    send(bca_pkg::CMD_ALLOC, 16'd398, 4'd0, 4'd0);        // leaves room 1 in block 1
    send(bca_pkg::CMD_FREE, 16'd0, 4'd1, 4'd2);           // middle chunk freed
    send(bca_pkg::CMD_FREE, 16'd0, 4'd1, 4'd2);           // freed twice
    send(bca_pkg::CMD_ALLOC, 16'd200, 4'd0, 4'd0);        // reuses whole freed chunk
    send(bca_pkg::CMD_FREE, 16'd0, 4'd1, 4'd9);           // slot not in use
    for (int i = 0; i < 10; i++) send(bca_pkg::CMD_ALLOC, 16'd1, 4'd0, 4'd0);  // one to block 1, rest to block 0
    send(bca_pkg::CMD_ALLOC, 16'hAAAA, 4'd5, 4'd10);

    for (int p = 0; p < 5; p++) begin
      if (p > 0) set_block_size(phase_sizes[p]);
      quiet = (p == 4);
      for (int i = 0; i < 176; i++) begin
        if (p == 1 && i == 20) hold_req = 1;
        random_item();
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d items over five block-size settings; %0d chunks were granted.",
             items_sent, grants_seen);
    if (errors == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
